/* rtl/bpcc_pkg.sv */
`default_nettype none
package bpcc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 31;
    localparam int unsigned MatDepth = 12;

    localparam logic signed [31:0] NearDepth = 32'sd327680;
    localparam logic signed [31:0] Int32Max = 32'sh7fff_ffff;
    localparam logic signed [31:0] Int32Min = 32'sh8000_0000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_FAR_DEPTH   = 3'd0,
        REG_FOCAL_SCALE = 3'd1,
        REG_VIEW_WIDTH  = 3'd2,
        REG_VIEW_HEIGHT = 3'd3,
        REG_CLIP_LEFT   = 3'd4,
        REG_CLIP_TOP    = 3'd5,
        REG_CLIP_RIGHT  = 3'd6,
        REG_CLIP_BOTTOM = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VIS_NONE = 2'd0,
        VIS_PART = 2'd1,
        VIS_FULL = 2'd2
    } t_vis;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef struct packed {
        logic               en;
        logic               clr;
        logic signed [31:0] a;
        logic signed [15:0] b;
    } t_mac_req;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic [30:0]        den;
    } t_div_req;

endpackage
`default_nettype wire

/* rtl/bpcc_in_if.sv */
`default_nettype none
interface bpcc_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [3:0]         matrix_slot;
    logic signed [31:0] matrix_word;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;

    modport source (output valid, func, matrix_slot, matrix_word,
                    min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink (input valid, func, matrix_slot, matrix_word,
                  min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface
`default_nettype wire

/* rtl/bpcc_out_if.sv */
`default_nettype none
interface bpcc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] visibility;

    modport source (output valid, visibility, input ready);
    modport sink (input valid, visibility, output ready);
endinterface
`default_nettype wire

/* rtl/bpcc_mac.sv */
`default_nettype none
module bpcc_mac
    import bpcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_mac_req    i_req,
    output logic signed [31:0] o_acc
);

    logic signed [31:0] r_prod;
    logic               r_pv;
    logic signed [31:0] r_acc;
    logic signed [47:0] n_prod;

    assign n_prod = i_req.a * i_req.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_req.en;
        end
        r_prod <= n_prod[31:0];
        // products wrap at 32 bits
        if (i_req.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

/* rtl/bpcc_div.sv */
`default_nettype none
module bpcc_div
    import bpcc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_div_req      i_req,
    output logic               o_done,
    output logic signed [31:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic [30:0] r_den;
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] n_shift;
    logic        n_ge;

    assign n_shift = {r_r[30:0], r_q[31]};
    assign n_ge    = n_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_neg <= i_req.num[31];
            r_den <= i_req.den;
            r_q   <= i_req.num[31] ? 32'(-i_req.num) : i_req.num;
            r_r   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_r   <= n_ge ? n_shift - {1'b0, r_den} : n_shift;
            r_q   <= {r_q[30:0], n_ge};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule
`default_nettype wire

/* rtl/box_projection_clip_classifier.sv */
// load request: writes one matrix slot while idle, no result
// check request: one result, from the depth rows alone when no corner is in depth range,
// from all rows when all eight are; each kept corner runs three divisions
// on the shared divider and three 4-term dot products on the shared multiplier
// one request at a time; input ready only while idle
// synchronous active-low reset clears matrix to zero and registers to their defaults
`default_nettype none
module box_projection_clip_classifier
    import bpcc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    bpcc_in_if.sink                  in_if,
    bpcc_out_if.source               out_if
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_ROW, S_EVAL, S_DIV, S_NEXT, S_FIN1, S_FIN2, S_OUT
    } t_state;

    t_state r_state;

    logic [30:0] r_far;
    logic [15:0] r_focal;
    logic [12:0] r_vw, r_vh;
    logic [11:0] r_cl, r_ct, r_cr, r_cb;

    logic signed [31:0] r_mat [MatDepth];

    logic signed [15:0] r_lo [3];
    logic signed [15:0] r_hi [3];
    logic [2:0]  r_corner;
    logic [1:0]  r_row;
    logic [2:0]  r_step;
    logic [3:0]  r_count;
    logic [30:0] r_zp;
    logic signed [31:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic signed [31:0] r_xl, r_xh, r_yl, r_yh;
    logic [1:0]  r_vis;

    t_mac_req mac_req;
    t_div_req div_req;
    logic signed [31:0] acc;
    logic               div_done;
    logic signed [31:0] quo;
    logic signed [15:0] coord;
    logic [15:0]        focal;
    logic               z_out;

    bpcc_mac u_mac (.i_clk, .i_rst_n, .i_req(mac_req), .o_acc(acc));
    bpcc_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_done(div_done), .o_quo(quo));

    assign focal = (r_focal == '0) ? 16'd1 : r_focal;

    // corner coordinate for the current column; the bias column multiplies by one
    always_comb begin
        case (r_step[1:0])
            2'd0:    coord = ((r_corner + 3'd1) & 3'd2) != 3'd0 ? r_hi[0] : r_lo[0];
            2'd1:    coord = r_corner[1] ? r_hi[1] : r_lo[1];
            2'd2:    coord = r_corner[2] ? r_hi[2] : r_lo[2];
            default: coord = 16'sd1;
        endcase
    end

    assign mac_req.en  = (r_state == S_ROW) && (r_step != 3'd4);
    assign mac_req.clr = (r_state == S_ROW) && (r_step == 3'd0);
    assign mac_req.a   = r_mat[{r_row, r_step[1:0]}];
    assign mac_req.b   = coord;

    assign z_out = (acc <= NearDepth) || (acc >= $signed({1'b0, r_far}));

    assign div_req.start = (r_state == S_EVAL) && !((r_row == 2'd2) && z_out);
    assign div_req.num   = acc;
    assign div_req.den   = (r_row == 2'd2) ? {15'd0, focal} : r_zp;

    assign in_if.ready       = (r_state == S_IDLE);
    assign out_if.valid      = (r_state == S_OUT);
    assign out_if.visibility = r_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far   <= 31'd335544320;
            r_focal <= 16'd320;
            r_vw    <= 13'd640;
            r_vh    <= 13'd480;
            r_cl    <= 12'd0;
            r_ct    <= 12'd0;
            r_cr    <= 12'd639;
            r_cb    <= 12'd479;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_FAR_DEPTH:   r_far   <= i_cfg_data;
                REG_FOCAL_SCALE: r_focal <= i_cfg_data[15:0];
                REG_VIEW_WIDTH:  r_vw    <= i_cfg_data[12:0];
                REG_VIEW_HEIGHT: r_vh    <= i_cfg_data[12:0];
                REG_CLIP_LEFT:   r_cl    <= i_cfg_data[11:0];
                REG_CLIP_TOP:    r_ct    <= i_cfg_data[11:0];
                REG_CLIP_RIGHT:  r_cr    <= i_cfg_data[11:0];
                REG_CLIP_BOTTOM: r_cb    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < MatDepth; k++) begin
                r_mat[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_if.valid) begin
                        if (in_if.func == FUNC_LOAD) begin
                            if (in_if.matrix_slot < 4'(MatDepth)) begin
                                r_mat[in_if.matrix_slot] <= in_if.matrix_word;
                            end
                        end else begin
                            r_lo[0] <= in_if.min_x;
                            r_lo[1] <= in_if.min_y;
                            r_lo[2] <= in_if.min_z;
                            r_hi[0] <= in_if.max_x;
                            r_hi[1] <= in_if.max_y;
                            r_hi[2] <= in_if.max_z;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_xmin   <= Int32Max;
                    r_ymin   <= Int32Max;
                    r_xmax   <= Int32Min;
                    r_ymax   <= Int32Min;
                    r_count  <= '0;
                    r_corner <= '0;
                    r_row    <= 2'd2;
                    r_step   <= '0;
                    // translation depth already at or beyond far plane
                    if (r_mat[MatDepth-1] >= $signed({1'b0, r_far})) begin
                        r_vis   <= VIS_NONE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (r_step == 3'd4) begin
                        r_step  <= '0;
                        r_state <= S_EVAL;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_EVAL: begin
                    r_state <= div_req.start ? S_DIV : S_NEXT;
                end
                S_DIV: begin
                    if (div_done) begin
                        unique case (r_row)
                            2'd2: begin
                                r_zp    <= (quo == '0) ? 31'd1 : quo[30:0];
                                r_count <= r_count + 4'd1;
                                r_row   <= 2'd0;
                                r_state <= S_ROW;
                            end
                            2'd0: begin
                                if (quo < r_xmin) r_xmin <= quo;
                                if (quo > r_xmax) r_xmax <= quo;
                                r_row   <= 2'd1;
                                r_state <= S_ROW;
                            end
                            default: begin
                                if (quo < r_ymin) r_ymin <= quo;
                                if (quo > r_ymax) r_ymax <= quo;
                                r_state <= S_NEXT;
                            end
                        endcase
                    end
                end
                S_NEXT: begin
                    r_row <= 2'd2;
                    if (r_corner == 3'd7) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_corner <= r_corner + 3'd1;
                        r_state  <= S_ROW;
                    end
                end
                S_FIN1: begin
                    r_xl <= r_xmin + $signed({20'd0, r_vw[12:1]});
                    r_xh <= r_xmax + $signed({20'd0, r_vw[12:1]});
                    r_yl <= r_ymin + $signed({20'd0, r_vh[12:1]});
                    r_yh <= r_ymax + $signed({20'd0, r_vh[12:1]});
                    if (r_count == '0) begin
                        r_vis   <= VIS_NONE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FIN2;
                    end
                end
                S_FIN2: begin
                    if (r_xl > $signed({20'd0, r_cr}) || r_yl > $signed({20'd0, r_cb}) ||
                        r_xh < $signed({20'd0, r_cl}) || r_yh < $signed({20'd0, r_ct})) begin
                        r_vis <= VIS_NONE;
                    end else if (r_count != 4'd8 || r_xl[31] || r_yl[31] ||
                                 r_xh >= $signed({19'd0, r_vw}) ||
                                 r_yh >= $signed({19'd0, r_vh})) begin
                        r_vis <= VIS_PART;
                    end else begin
                        r_vis <= VIS_FULL;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_if.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
